FILE: rtl/core/fagc_pkg.sv
// ----------------------------------------------------------------------------
// fagc_pkg
// Shared types and constants of the feedback AGC: datapath opcodes, the
// controller/datapath command and status words, and register map.
// ----------------------------------------------------------------------------
package fagc_pkg;

    localparam int GAIN_W     = 32;
    localparam int RATE_W     = 24;
    localparam int LEVEL_W    = 16;
    localparam int CEIL_W     = 31;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CEILING = 3'd4;

    // reset values
    localparam logic                     RST_COMPLEX_MODE = 1'b1;
    localparam logic [RATE_W-1:0]        RST_ADAPT_RATE   = 24'd1678;
    localparam logic [LEVEL_W-1:0]       RST_TARGET_LEVEL = 16'd32767;
    localparam logic signed [GAIN_W-1:0] RST_GAIN         = 32'sd65536;
    localparam logic [CEIL_W-1:0]        RST_GAIN_CEILING = 31'd4294967;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL_I,
        DP_MUL_Q,
        DP_REAL,
        DP_SQ_I,
        DP_SQ_Q,
        DP_SUM,
        DP_SQRT,
        DP_ERR,
        DP_RATE,
        DP_UPD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic complex_mode;
    } dp_status_t;

endpackage

FILE: rtl/core/feedback_agc_real_complex_unit.sv
// ----------------------------------------------------------------------------
// feedback_agc_real_complex_unit
// Sample-by-sample feedback AGC on real or complex words.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one input word (sample_i, sample_q); m_* returns one scaled
//   word per input. Both use valid/ready; a word moves when both are high.
//   cfg_* writes a register (index 0..4); cfg_ready is always high. Write
//   only while the unit is idle. Writing initial_gain reloads the gain.
// Sequence:
//   Complex mode: the single shared multiplier scales I, scales Q, squares I,
//   squares Q and later forms rate times error; between them the bit-serial
//   square root (one root bit per cycle) gives the magnitude before m_valid
//   rises. Real mode skips the magnitude path.
//   One word is in flight at a time; s_ready rises together with m_valid, so
//   no new word is taken until the last one has reached the output register.
// Reset: clears the handshakes, loads the register defaults and a gain of
//   1.0. A stalled receiver holds the result in the output register; the
//   unit then finishes the next word and waits before the gain update.
// ----------------------------------------------------------------------------
module feedback_agc_real_complex_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_i,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_q,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [SAMPLE_BITS-1:0]    m_out_i,
    output logic signed [SAMPLE_BITS-1:0]    m_out_q,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fagc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fagc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fagc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    fagc_ctrl #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fagc_datapath #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_i      (s_sample_i),
        .in_q      (s_sample_q),
        .out_i     (m_out_i),
        .out_q     (m_out_q)
    );

endmodule

FILE: rtl/core/fagc_datapath.sv
// ----------------------------------------------------------------------------
// fagc_datapath
// Configuration registers, running gain, one shared signed multiplier,
// saturation, bit-serial square root and the gain update.
// ----------------------------------------------------------------------------
module fagc_datapath #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fagc_pkg::dp_cmd_t                cmd,
    output fagc_pkg::dp_status_t             status,
    input  logic                             cfg_we,
    input  logic [fagc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fagc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]    in_i,
    input  logic signed [SAMPLE_BITS-1:0]    in_q,
    output logic signed [SAMPLE_BITS-1:0]    out_i,
    output logic signed [SAMPLE_BITS-1:0]    out_q
);
    import fagc_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int A_W    = (SB > RATE_W + 1) ? SB : RATE_W + 1;
    localparam int B_W    = GAIN_W;
    localparam int P_W    = A_W + B_W;
    localparam int N_W    = P_W + 1;
    localparam int ERR_W  = ((SB > LEVEL_W) ? SB : LEVEL_W) + 2;
    localparam int SQ_W   = 2 * SB;
    localparam int REM_W  = SB + 2;
    localparam int STEP_W = SB + 4;
    localparam int SHIFT  = SB + 7;

    localparam logic signed [P_W-1:0] S_MAX = {{(P_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [P_W-1:0] S_MIN = {{(P_W-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic signed [N_W-1:0] G_MAX = {{(N_W-GAIN_W+1){1'b0}}, {(GAIN_W-1){1'b1}}};
    localparam logic signed [N_W-1:0] G_MIN = {{(N_W-GAIN_W+1){1'b1}}, {(GAIN_W-1){1'b0}}};

    logic                        complex_reg;
    logic [RATE_W-1:0]           rate_reg;
    logic [LEVEL_W-1:0]          target_reg;
    logic [CEIL_W-1:0]           ceil_reg;
    logic signed [GAIN_W-1:0]    gain_reg;
    logic signed [GAIN_W-1:0]    gain_next;

    logic signed [SB-1:0]        si_reg;
    logic signed [SB-1:0]        sq_reg;
    logic signed [SB-1:0]        oi_reg;
    logic signed [SB-1:0]        oq_reg;
    logic signed [SB-1:0]        out_i_reg;
    logic signed [SB-1:0]        out_q_reg;
    logic signed [P_W-1:0]       prod_reg;
    logic [SQ_W-1:0]             acc_reg;
    logic [SQ_W-1:0]             rad_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [SB-1:0]               root_reg;
    logic signed [ERR_W-1:0]     err_reg;

    logic signed [A_W-1:0]       mul_a;
    logic signed [B_W-1:0]       mul_b;
    logic signed [P_W-1:0]       scaled;
    logic signed [SB-1:0]        sat_val;
    logic signed [SB:0]          sat_abs;
    logic [STEP_W-1:0]           rem_try;
    logic [STEP_W-1:0]           trial;
    logic [STEP_W-1:0]           rem_diff;
    logic signed [P_W-1:0]       delta;
    logic signed [N_W-1:0]       gain_sum;
    logic signed [GAIN_W-1:0]    gain_sat;

    assign status.complex_mode = complex_reg;
    assign out_i = out_i_reg;
    assign out_q = out_q_reg;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_MUL_I: begin
                mul_a = A_W'(si_reg);
                mul_b = gain_reg;
            end
            DP_MUL_Q: begin
                mul_a = A_W'(sq_reg);
                mul_b = gain_reg;
            end
            DP_SQ_I: begin
                mul_a = A_W'(oi_reg);
                mul_b = B_W'(oi_reg);
            end
            DP_SQ_Q: begin
                mul_a = A_W'(oq_reg);
                mul_b = B_W'(oq_reg);
            end
            DP_RATE: begin
                mul_a = A_W'($signed({1'b0, rate_reg}));
                mul_b = B_W'(err_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // floor shift by the gain fraction, then clip to the sample range
    always_comb begin
        scaled = prod_reg >>> FRAC_BITS;
        if (scaled > S_MAX) begin
            sat_val = S_MAX[SB-1:0];
        end else if (scaled < S_MIN) begin
            sat_val = S_MIN[SB-1:0];
        end else begin
            sat_val = scaled[SB-1:0];
        end
        sat_abs = sat_val[SB-1] ? -(SB+1)'(sat_val) : (SB+1)'(sat_val);
    end

    // one result bit per step: bring down two radicand bits
    always_comb begin
        rem_try  = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        rem_diff = rem_try - trial;
    end

    // gain update: floor-scaled step, clip to 32 bits, then the ceiling
    always_comb begin
        delta    = prod_reg >>> SHIFT;
        gain_sum = N_W'(gain_reg) + N_W'(delta);
        if (gain_sum > G_MAX) begin
            gain_sat = G_MAX[GAIN_W-1:0];
        end else if (gain_sum < G_MIN) begin
            gain_sat = G_MIN[GAIN_W-1:0];
        end else begin
            gain_sat = gain_sum[GAIN_W-1:0];
        end
        gain_next = gain_sat;
        if (ceil_reg != '0 && gain_sat > $signed({1'b0, ceil_reg})) begin
            gain_next = $signed({1'b0, ceil_reg});
        end
    end

    // configuration and running gain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            complex_reg <= RST_COMPLEX_MODE;
            rate_reg    <= RST_ADAPT_RATE;
            target_reg  <= RST_TARGET_LEVEL;
            ceil_reg    <= RST_GAIN_CEILING;
            gain_reg    <= RST_GAIN;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_COMPLEX_MODE: complex_reg <= cfg_data[0];
                CFG_ADAPT_RATE:   rate_reg    <= cfg_data[RATE_W-1:0];
                CFG_TARGET_LEVEL: target_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_INITIAL_GAIN: gain_reg    <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_GAIN_CEILING: ceil_reg    <= cfg_data[CEIL_W-1:0];
                default: ;
            endcase
        end else if (cmd.op == DP_UPD) begin
            gain_reg <= gain_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_MUL_I, DP_MUL_Q, DP_SQ_I, DP_SQ_Q, DP_RATE: begin
                prod_reg <= P_W'(mul_a * mul_b);
            end
            default: ;
        endcase
        case (cmd.op)
            DP_LOAD: begin
                si_reg <= in_i;
                sq_reg <= in_q;
            end
            DP_MUL_Q: oi_reg <= sat_val;
            DP_REAL: begin
                oi_reg  <= sat_val;
                oq_reg  <= '0;
                err_reg <= ERR_W'($signed({1'b0, target_reg})) - ERR_W'(sat_abs);
            end
            DP_SQ_I: oq_reg  <= sat_val;
            DP_SQ_Q: acc_reg <= prod_reg[SQ_W-1:0];
            DP_SUM: begin
                rad_reg  <= acc_reg + prod_reg[SQ_W-1:0];
                rem_reg  <= '0;
                root_reg <= '0;
            end
            DP_SQRT: begin
                rad_reg <= rad_reg << 2;
                if (rem_try >= trial) begin
                    rem_reg  <= rem_diff[REM_W-1:0];
                    root_reg <= {root_reg[SB-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_try[REM_W-1:0];
                    root_reg <= {root_reg[SB-2:0], 1'b0};
                end
            end
            DP_ERR: begin
                err_reg <= ERR_W'($signed({1'b0, target_reg}))
                         - ERR_W'($signed({1'b0, root_reg}));
            end
            DP_UPD: begin
                out_i_reg <= oi_reg;
                out_q_reg <= oq_reg;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/fagc_ctrl.sv
// ----------------------------------------------------------------------------
// fagc_ctrl
// Sequencer of the feedback AGC: steps the datapath through scaling,
// magnitude (complex mode only), error and gain update, and owns both stream handshakes.
// ----------------------------------------------------------------------------
module fagc_ctrl #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  fagc_pkg::dp_status_t  status,
    output fagc_pkg::dp_cmd_t     cmd
);
    import fagc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_BITS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_MUL_Q,
        ST_REAL,
        ST_SQ_I,
        ST_SQ_Q,
        ST_SUM,
        ST_SQRT,
        ST_ERR,
        ST_RATE,
        ST_UPD
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              m_valid_reg;
    logic              out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (state_reg)
            ST_IDLE:  cmd.op = (s_valid) ? DP_LOAD : DP_NOP;
            ST_MUL_I: cmd.op = DP_MUL_I;
            ST_MUL_Q: cmd.op = DP_MUL_Q;
            ST_REAL:  cmd.op = DP_REAL;
            ST_SQ_I:  cmd.op = DP_SQ_I;
            ST_SQ_Q:  cmd.op = DP_SQ_Q;
            ST_SUM:   cmd.op = DP_SUM;
            ST_SQRT:  cmd.op = DP_SQRT;
            ST_ERR:   cmd.op = DP_ERR;
            ST_RATE:  cmd.op = DP_RATE;
            ST_UPD:   cmd.op = (out_free) ? DP_UPD : DP_NOP;
            default:  cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_MUL_I;
                    end
                end
                ST_MUL_I: state_reg <= status.complex_mode ? ST_MUL_Q : ST_REAL;
                ST_MUL_Q: state_reg <= ST_SQ_I;
                ST_REAL:  state_reg <= ST_RATE;
                ST_SQ_I:  state_reg <= ST_SQ_Q;
                ST_SQ_Q:  state_reg <= ST_SUM;
                ST_SUM: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (cnt_reg == CNT_LAST) begin
                        state_reg <= ST_ERR;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ERR:  state_reg <= ST_RATE;
                ST_RATE: state_reg <= ST_UPD;
                ST_UPD: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: dv/feedback_agc_real_complex_unit_tb.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// feedback_agc_real_complex_unit_tb
// Streams real and complex sample words through the AGC under random flow
// control on both sides. It tracks the running gain and register settings
// alongside the unit and compares every scaled word with the prediction.
// ----------------------------------------------------------------------------
module feedback_agc_real_complex_unit_tb;
    import fagc_pkg::*;

    localparam int     SB            = 16;
    localparam int     WORD_TARGET   = 650;
    localparam int     LIMIT_CYCLES  = 500000;
    localparam int     SETTLE_CYCLES = 30;
    localparam int     BACKLOG_HOLD  = 400;
    localparam longint SAMPLE_MAX    = 32767;
    localparam longint SAMPLE_MIN    = -32768;
    localparam longint GAIN_MAX      = 64'sd2147483647;
    localparam longint GAIN_MIN      = -64'sd2147483648;

    // indexes outside the register map, written to check they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef logic signed [SB-1:0] sample_t;

    typedef struct packed {
        sample_t i;
        sample_t q;
    } word_t;

    typedef struct {
        bit                    wr;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        sample_t               si;
        sample_t               sq;
        bit                    known;
        word_t                 typed_out;
    } row_t;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    sample_t               s_sample_i = '0;
    sample_t               s_sample_q = '0;
    logic                  m_ready    = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  s_ready;
    logic                  m_valid;
    sample_t               m_out_i;
    sample_t               m_out_q;
    logic                  cfg_ready;

    // gain loop state as the unit should hold it
    bit                        mode_cplx = RST_COMPLEX_MODE;
    logic [RATE_W-1:0]         rate      = RST_ADAPT_RATE;
    logic [LEVEL_W-1:0]        level     = RST_TARGET_LEVEL;
    logic [CEIL_W-1:0]         ceiling   = RST_GAIN_CEILING;
    logic signed [GAIN_W-1:0]  gain      = RST_GAIN;

    word_t pending_words[$];
    row_t  directed_rows[$];
    int    errors      = 0;
    int    cycles      = 0;
    bit    steady      = 1'b0;
    bit    backlog_req = 1'b0;

    feedback_agc_real_complex_unit #(
        .SAMPLE_BITS(SB)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample_i (s_sample_i),
        .s_sample_q (s_sample_q),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_i    (m_out_i),
        .m_out_q    (m_out_q),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("feedback_agc_real_complex_unit_tb failed");
            $finish;
        end
    end

    // sample times gain, floored to the sample grid and clipped
    function automatic sample_t clip_scaled(sample_t s, logic signed [GAIN_W-1:0] g);
        longint p;
        p = (longint'(s) * longint'(g)) >>> FRAC_BITS;
        if (p > SAMPLE_MAX)
            p = SAMPLE_MAX;
        else if (p < SAMPLE_MIN)
            p = SAMPLE_MIN;
        return sample_t'(p);
    endfunction

    function automatic longint floor_root(longint x);
        longint r;
        longint t;
        r = 0;
        for (int k = 16; k >= 0; k--) begin
            t = r | (longint'(1) << k);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // scale one word and move the gain toward the target level
    function automatic word_t agc_scale(sample_t si, sample_t sq);
        sample_t oi;
        sample_t oq;
        longint  mag;
        longint  adj;
        longint  next_g;
        word_t   w;
        oi = clip_scaled(si, gain);
        oq = '0;
        if (mode_cplx) begin
            oq  = clip_scaled(sq, gain);
            mag = floor_root(longint'(oi) * longint'(oi) + longint'(oq) * longint'(oq));
        end else begin
            mag = (oi < 0) ? -longint'(oi) : longint'(oi);
        end
        adj    = (longint'(rate) * (longint'(level) - mag)) >>> (SB + 7);
        next_g = longint'(gain) + adj;
        if (next_g > GAIN_MAX)
            next_g = GAIN_MAX;
        else if (next_g < GAIN_MIN)
            next_g = GAIN_MIN;
        if (ceiling != 0 && next_g > longint'(ceiling))
            next_g = longint'(ceiling);
        gain = GAIN_W'(next_g);
        w.i  = oi;
        w.q  = oq;
        return w;
    endfunction

    function automatic void agc_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_COMPLEX_MODE: mode_cplx = d[0];
            CFG_ADAPT_RATE:   rate = d[RATE_W-1:0];
            CFG_TARGET_LEVEL: level = d[LEVEL_W-1:0];
            CFG_INITIAL_GAIN: gain = d;
            CFG_GAIN_CEILING: ceiling = d[CEIL_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        row_t r;
        r     = '{default: '0};
        r.wr   = 1'b1;
        r.idx  = idx;
        r.data = d;
        directed_rows.push_back(r);
    endfunction

    function automatic void word_row(sample_t si, sample_t sq);
        row_t r;
        r    = '{default: '0};
        r.si = si;
        r.sq = sq;
        directed_rows.push_back(r);
    endfunction

    function automatic void known_row(sample_t si, sample_t sq, sample_t ei, sample_t eq);
        row_t r;
        r             = '{default: '0};
        r.si          = si;
        r.sq          = sq;
        r.known       = 1'b1;
        r.typed_out.i = ei;
        r.typed_out.q = eq;
        directed_rows.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
            1: return sample_t'(int'($urandom_range(0, 64)) - 32);
            2: return sample_t'(int'($urandom_range(0, 4000)) - 2000);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_word(sample_t si, sample_t sq, bit known, word_t typed_out);
        word_t w;
        int    gap;
        s_valid    <= 1'b1;
        s_sample_i <= si;
        s_sample_q <= sq;
        do @(posedge aclk); while (!s_ready);
        w = agc_scale(si, sq);
        pending_words.push_back(known ? typed_out : w);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop valid, wait for every scaled word, then let the gain update land
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        agc_write(idx, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : result_side
        int    hold;
        int    r;
        word_t want;
        hold = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected word: out_i %0d out_q %0d", m_out_i, m_out_q);
                    errors++;
                end else begin
                    want = pending_words.pop_front();
                    if (m_out_i !== want.i) begin
                        $error("out_i: expected %0d, got %0d", $signed(want.i), m_out_i);
                        errors++;
                    end
                    if (m_out_q !== want.q) begin
                        $error("out_q: expected %0d, got %0d", $signed(want.q), m_out_q);
                        errors++;
                    end
                end
            end
            if (backlog_req) begin
                backlog_req = 1'b0;
                hold = BACKLOG_HOLD;
            end else if (hold == 0 && !steady && $urandom_range(0, 99) < 25) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    hold = $urandom_range(1, 3);
                else if (r < 97)
                    hold = $urandom_range(4, 12);
                else
                    hold = $urandom_range(20, 60);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        bit                    busy;
        int                    sent;
        int                    phase;
        int                    n_words;
        logic [CFG_DATA_W-1:0] d;

        // gain 1.0 after reset, then full scale
        known_row(100, -200, 100, -200);
        cfg_row(CFG_INITIAL_GAIN, 32'h0001_0000);
        known_row(32767, -32768, 32767, -32768);
        // largest gain: floor rounds the negative product down, ceiling kicks in
        cfg_row(CFG_INITIAL_GAIN, 32'h7FFF_FFFF);
        known_row(1, -1, 32767, -32768);
        known_row(32767, 32767, 32767, 32767);
        known_row(-32768, 32767, -32768, 32767);
        // most negative gain inverts the sample and clips it at both ends of the range
        cfg_row(CFG_INITIAL_GAIN, 32'h8000_0000);
        known_row(1, -1, -32768, 32767);
        known_row(0, 0, 0, 0);
        known_row(-32768, 32767, 32767, -32768);
        cfg_row(CFG_SPARE_A, 32'hFFFF_FFFF);
        cfg_row(CFG_SPARE_B, 32'h0000_0000);
        // real mode zeroes the Q output
        cfg_row(CFG_COMPLEX_MODE, 32'd0);
        cfg_row(CFG_INITIAL_GAIN, 32'h0001_0000);
        known_row(-1234, 5555, -1234, 0);
        known_row(-32768, -32768, -32768, 0);
        known_row(32767, -1, 32767, 0);
        // zero ceiling: gain runs up to the top of the gain range
        cfg_row(CFG_GAIN_CEILING, 32'd0);
        cfg_row(CFG_ADAPT_RATE, 32'h00FF_FFFF);
        cfg_row(CFG_TARGET_LEVEL, 32'h0000_FFFF);
        cfg_row(CFG_INITIAL_GAIN, 32'h7FFF_FFFF);
        known_row(0, 32767, 0, 0);
        known_row(1, 0, 32767, 0);
        // frozen half gain shows floor rounding on both signs
        cfg_row(CFG_COMPLEX_MODE, 32'd1);
        cfg_row(CFG_ADAPT_RATE, 32'd0);
        cfg_row(CFG_INITIAL_GAIN, 32'h0000_8000);
        known_row(1001, -1001, 500, -501);
        known_row(-3, 3, -2, 1);
        cfg_row(CFG_GAIN_CEILING, 32'hFFFF_FFFF);
        cfg_row(CFG_ADAPT_RATE, RST_ADAPT_RATE);
        cfg_row(CFG_TARGET_LEVEL, 32'd0);
        cfg_row(CFG_INITIAL_GAIN, RST_GAIN);
        word_row(20000, 20000);
        word_row(-20000, 12345);
        word_row(32767, -32768);
        word_row(-1, -1);
        cfg_row(CFG_TARGET_LEVEL, 32'h0000_FFFF);
        cfg_row(CFG_ADAPT_RATE, 32'h0000_FFFF);
        cfg_row(CFG_INITIAL_GAIN, 32'h0000_0001);
        word_row(5, -7);
        word_row(-32768, -32768);
        word_row(12, 0);
        word_row(32767, 1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        busy = 1'b0;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].wr) begin
                if (busy)
                    drain();
                busy = 1'b0;
                write_reg(directed_rows[k].idx, directed_rows[k].data);
            end else begin
                send_word(directed_rows[k].si, directed_rows[k].sq,
                          directed_rows[k].known, directed_rows[k].typed_out);
                busy = 1'b1;
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < WORD_TARGET) begin
            drain();
            steady = ($urandom_range(0, 3) == 0);
            write_reg(CFG_COMPLEX_MODE, $urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0: d = 32'd0;
                1: d = 32'h00FF_FFFF;
                2: d = $urandom;
                default: d = $urandom_range(100, 40000);
            endcase
            write_reg(CFG_ADAPT_RATE, d);
            case ($urandom_range(0, 5))
                0: d = 32'd0;
                1: d = 32'h0000_FFFF;
                default: d = $urandom_range(2000, 40000);
            endcase
            write_reg(CFG_TARGET_LEVEL, d);
            case ($urandom_range(0, 7))
                0: d = 32'h8000_0000;
                1: d = 32'h7FFF_FFFF;
                2: d = -$urandom_range(1, 32'h0003_0000);
                3: d = $urandom;
                default: d = $urandom_range(32'h0000_1000, 32'h0004_0000);
            endcase
            write_reg(CFG_INITIAL_GAIN, d);
            case ($urandom_range(0, 5))
                0: d = 32'd0;
                1: d = 32'hFFFF_FFFF;
                2: d = $urandom;
                default: d = $urandom_range(32'h0001_0000, 32'h0080_0000);
            endcase
            write_reg(CFG_GAIN_CEILING, d);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);

            n_words = $urandom_range(40, 90);
            for (int n = 0; n < n_words && sent < WORD_TARGET; n++) begin
                // stall the receiver long enough to back the unit up
                if (phase == 3 && n == 5)
                    backlog_req = 1'b1;
                // hold the sender until the unit has emptied
                if (phase == 5 && n == 20)
                    drain();
                send_word(pick_sample(), pick_sample(), 1'b0, '0);
                sent++;
            end
            phase++;
        end

        drain();
        if (errors == 0)
            $display("feedback_agc_real_complex_unit_tb passed");
        else
            $display("feedback_agc_real_complex_unit_tb failed");
        $finish;
    end

endmodule
